### sv/tdpt_pkg.sv
package tdpt_pkg;

  // classification of an accepted number, made by the front end
  typedef enum logic [1:0] {
    KIND_BELOW_TWO,
    KIND_SMALL_PRIME,
    KIND_SEARCH
  } kind_e;

  localparam int KIND_W    = 2;
  localparam int VERDICT_W = 2;
  localparam int REPORT_W  = 32;
  localparam int LIMIT_W   = 32;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_PRIME     = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_COMPOSITE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TIMEOUT   = 2'd2;

  localparam logic [LIMIT_W-1:0]  TRIAL_LIMIT_RESET = 32'd65535;
  localparam logic [REPORT_W-1:0] REPORT_TIMEOUT    = '1;

  // entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

endpackage

### sv/tdpt_front.sv
module tdpt_front
  import tdpt_pkg::*;
#(
  parameter int NUMBER_BITS = 31,
  parameter int SLOT_BITS   = 8,
  localparam int ENTRY_W    = NUMBER_BITS + SLOT_BITS + KIND_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NUMBER_BITS-1:0] in_number_i,
  input  logic [SLOT_BITS-1:0]   in_slot_i,
  output logic                   ent_valid_o,
  input  logic                   ent_ready_i,
  output logic [ENTRY_W-1:0]     ent_data_o
);

  logic               valid_q;
  logic [ENTRY_W-1:0] entry_q;
  kind_e              kind;

  assign in_ready_o  = !valid_q || ent_ready_i;
  assign ent_valid_o = valid_q;
  assign ent_data_o  = entry_q;

  // classify by size: below two, two or three, or a full search
  always_comb begin
    if ((in_number_i >> 1) == '0) begin
      kind = KIND_BELOW_TWO;
    end else if ((in_number_i >> 2) == '0) begin
      kind = KIND_SMALL_PRIME;
    end else begin
      kind = KIND_SEARCH;
    end
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      entry_q <= {kind, in_slot_i, in_number_i};
    end
  end

endmodule

### sv/tdpt_queue.sv
module tdpt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign in_ready_o  = count_q != CNT_W'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

### sv/tdpt_back.sv
module tdpt_back
  import tdpt_pkg::*;
#(
  parameter int NUMBER_BITS = 31,
  parameter int SLOT_BITS   = 8,
  localparam int ENTRY_W    = NUMBER_BITS + SLOT_BITS + KIND_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LIMIT_W-1:0]     trial_limit_i,
  input  logic                   ent_valid_i,
  output logic                   ent_ready_o,
  input  logic [ENTRY_W-1:0]     ent_data_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [VERDICT_W-1:0]   res_verdict_o,
  output logic [REPORT_W-1:0]    res_report_o,
  output logic [SLOT_BITS-1:0]   res_slot_o
);

  // divisor never exceeds 2^ceil(NUMBER_BITS/2)
  localparam int DW    = (NUMBER_BITS + 1) / 2 + 1;
  localparam int SQW   = 2 * DW;
  localparam int BIT_W = $clog2(NUMBER_BITS);
  localparam int CMP_W = (DW > LIMIT_W) ? DW : LIMIT_W;
  localparam int FUL_W = (NUMBER_BITS > LIMIT_W) ? NUMBER_BITS : LIMIT_W;
  localparam int EXT_W = (NUMBER_BITS > REPORT_W) ? NUMBER_BITS : REPORT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRIAL,
    S_DIV,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [NUMBER_BITS-1:0] num_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [DW-1:0]          d_q;
  logic [SQW-1:0]         sq_q;
  logic [DW-1:0]          rem_q;
  logic [BIT_W-1:0]       bit_q;
  logic [VERDICT_W-1:0]   verdict_q;
  logic [REPORT_W-1:0]    report_q;
  logic                   out_valid_q;
  logic [VERDICT_W-1:0]   out_verdict_q;
  logic [REPORT_W-1:0]    out_report_q;
  logic [SLOT_BITS-1:0]   out_slot_q;

  logic [NUMBER_BITS-1:0] ent_number;
  logic [SLOT_BITS-1:0]   ent_slot;
  kind_e                  ent_kind;
  logic [REPORT_W-1:0]    ent_pos, ent_neg, num_pos, num_neg;
  logic [NUMBER_BITS-1:0] half, full;
  logic                   sq_past, trial_over, full_over, out_free;
  logic [DW:0]            rem_shift;
  logic [DW-1:0]          rem_next;

  assign ent_number = ent_data_i[NUMBER_BITS-1:0];
  assign ent_slot   = ent_data_i[NUMBER_BITS +: SLOT_BITS];
  assign ent_kind   = kind_e'(ent_data_i[NUMBER_BITS + SLOT_BITS +: KIND_W]);

  // low report bits of a number and of its negation
  assign ent_pos = REPORT_W'(EXT_W'(ent_number));
  assign ent_neg = REPORT_W'(EXT_W'(0) - EXT_W'(ent_number));
  assign num_pos = REPORT_W'(EXT_W'(num_q));
  assign num_neg = REPORT_W'(EXT_W'(0) - EXT_W'(num_q));

  // loop end and budget checks
  assign sq_past    = sq_q > SQW'(num_q);
  assign trial_over = CMP_W'(d_q - DW'(1)) > CMP_W'(trial_limit_i);
  assign half       = num_q >> 1;
  assign full       = ((half >> 1) != '0) ? half - NUMBER_BITS'(1) : '0;
  assign full_over  = FUL_W'(full) > FUL_W'(trial_limit_i);

  // one remainder bit per cycle
  assign rem_shift = {rem_q, num_q[bit_q]};
  assign rem_next  = (rem_shift >= {1'b0, d_q}) ? DW'(rem_shift - {1'b0, d_q})
                                                 : rem_shift[DW-1:0];

  assign out_free    = !out_valid_q || res_ready_i;
  assign ent_ready_o = state_q == S_IDLE;

  assign res_valid_o   = out_valid_q;
  assign res_verdict_o = out_verdict_q;
  assign res_report_o  = out_report_q;
  assign res_slot_o    = out_slot_q;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (ent_valid_i) begin
            num_q  <= ent_number;
            slot_q <= ent_slot;
            d_q    <= DW'(2);
            sq_q   <= SQW'(4);
            unique case (ent_kind)
              KIND_BELOW_TWO: begin
                verdict_q <= VERDICT_COMPOSITE;
                report_q  <= ent_pos;
                state_q   <= S_DONE;
              end
              KIND_SMALL_PRIME: begin
                verdict_q <= VERDICT_PRIME;
                report_q  <= ent_neg;
                state_q   <= S_DONE;
              end
              default: begin
                state_q <= S_TRIAL;
              end
            endcase
          end
        end
        S_TRIAL: begin
          if (sq_past) begin
            verdict_q <= full_over ? VERDICT_TIMEOUT : VERDICT_PRIME;
            report_q  <= full_over ? REPORT_TIMEOUT : num_neg;
            state_q   <= S_DONE;
          end else if (trial_over) begin
            verdict_q <= VERDICT_TIMEOUT;
            report_q  <= REPORT_TIMEOUT;
            state_q   <= S_DONE;
          end else begin
            rem_q   <= '0;
            bit_q   <= BIT_W'(NUMBER_BITS - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_next;
          if (bit_q == '0) begin
            if (rem_next == '0) begin
              verdict_q <= VERDICT_COMPOSITE;
              report_q  <= num_pos;
              state_q   <= S_DONE;
            end else begin
              d_q     <= d_q + DW'(1);
              sq_q    <= sq_q + (SQW'(d_q) << 1) + SQW'(1);
              state_q <= S_TRIAL;
            end
          end else begin
            bit_q <= bit_q - BIT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_verdict_q <= verdict_q;
            out_report_q  <= report_q;
            out_slot_q    <= slot_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // remainder stays below the divisor during a division
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < d_q)
    else $error("remainder not below divisor");

  // divisor only steps between divisions
  a_div_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && bit_q != '0) |=> $stable(d_q))
    else $error("divisor changed within a division");

  // trial divisors start at two
  a_div_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIAL || state_q == S_DIV) |-> d_q >= DW'(2))
    else $error("divisor below two");

  // a result appears only after the sequencer finished an item
  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result without finished item");

endmodule

### sv/trial_division_prime_test.sv
// Trial-division primality tester. Each transaction on the slave stream carries a number
// and a slot tag; one result transaction follows on the master stream with a verdict
// (0 prime, 1 composite or below two, 2 timeout), a report value (the number if composite,
// its negation if prime, -1 on timeout) and the slot tag. Divisors from 2 up to the square
// root are tried; a prime whose full half-range scan would need more than trial_limit
// divisions, or a search that reaches trial_limit divisions, times out. At most the
// smaller of sqrt(n) - 1 and trial_limit divisors are tried; the remainder unit produces
// one quotient bit per cycle and is shared by all divisors. A front stage and a two-entry
// queue take new items while a test runs.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int NUMBER_BITS = 31,
  parameter int SLOT_BITS   = 8,
  localparam int IN_W       = ((NUMBER_BITS + SLOT_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((VERDICT_W + REPORT_W + SLOT_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write: trial_limit
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // test_number, slot_tag
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // verdict, report_value, slot_out
  output logic [OUT_W-1:0]   m_axis_tdata
);

  localparam int ENTRY_W = NUMBER_BITS + SLOT_BITS + KIND_W;
  localparam int RES_W   = VERDICT_W + REPORT_W + SLOT_BITS;

  logic [LIMIT_W-1:0]   limit_q;
  logic                 f_valid, f_ready, q_valid, q_ready;
  logic [ENTRY_W-1:0]   f_data, q_data;
  logic [VERDICT_W-1:0] res_verdict;
  logic [REPORT_W-1:0]  res_report;
  logic [SLOT_BITS-1:0] res_slot;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TRIAL_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // front end: accept and classify
  tdpt_front #(
    .NUMBER_BITS(NUMBER_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_number_i(s_axis_tdata[NUMBER_BITS-1:0]),
    .in_slot_i  (s_axis_tdata[NUMBER_BITS +: SLOT_BITS]),
    .ent_valid_o(f_valid),
    .ent_ready_i(f_ready),
    .ent_data_o (f_data)
  );

  // queue between front and back end
  tdpt_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  (f_data),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_data_o (q_data)
  );

  // back end: trial division
  tdpt_back #(
    .NUMBER_BITS(NUMBER_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .trial_limit_i(limit_q),
    .ent_valid_i  (q_valid),
    .ent_ready_o  (q_ready),
    .ent_data_i   (q_data),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_verdict_o(res_verdict),
    .res_report_o (res_report),
    .res_slot_o   (res_slot)
  );

  // result packing
  assign m_axis_tdata = OUT_W'({res_slot, res_report, res_verdict});

  // packed result width fits the bus
  a_out_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> RES_W) == '0)
    else $error("result padding not zero");

endmodule
